/* rtl/pixel_blend_unit_defines.svh */
// Assertion macros used by the checker file of the pixel blend unit.
// Every macro expects signals named clk and arst_n in the scope where it is used.
`ifndef PIXEL_BLEND_UNIT_DEFINES_SVH
`define PIXEL_BLEND_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBU_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pixel blend unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PBU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pixel blend unit: next-cycle check failed");

`endif

/* rtl/pbu_pkg.sv */
package pbu_pkg;

	// One input word: blend mode, source pixel and destination pixel.
	typedef struct packed {
		logic [3:0] mode;
		logic [7:0] src_blue;
		logic [7:0] src_green;
		logic [7:0] src_red;
		logic [7:0] src_alpha;
		logic [7:0] dst_blue;
		logic [7:0] dst_green;
		logic [7:0] dst_red;
		logic [7:0] dst_alpha;
	} pbu_in_t;

	// One result word: the blended pixel.
	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic [7:0] out_alpha;
	} pbu_out_t;

	// Controls shared by the three color channel datapaths.
	typedef struct packed {
		logic [3:0] mode;
		logic [7:0] weight;
	} pbu_chan_ctl_t;

	localparam logic [3:0] MODE_ADD       = 4'd0;
	localparam logic [3:0] MODE_ALPHA     = 4'd1;
	localparam logic [3:0] MODE_AVERAGE   = 4'd2;
	localparam logic [3:0] MODE_DARKEN    = 4'd3;
	localparam logic [3:0] MODE_LIGHTEN   = 4'd4;
	localparam logic [3:0] MODE_DIFF      = 4'd5;
	localparam logic [3:0] MODE_MULTIPLY  = 4'd6;
	localparam logic [3:0] MODE_SCREEN    = 4'd7;
	localparam logic [3:0] MODE_SRC_ALPHA = 4'd8;
	localparam logic [3:0] MODE_COPY      = 4'd9;

	localparam logic [7:0] CHAN_MAX        = 8'hFF;
	localparam logic [7:0] BLEND_ALPHA_RST = 8'd128;

endpackage

/* rtl/pbu_channel.sv */
module pbu_channel (
	input  pbu_pkg::pbu_chan_ctl_t ctl,
	input  logic [7:0]             s,
	input  logic [7:0]             d,
	output logic [7:0]             y
);
	import pbu_pkg::*;

	logic signed [9:0]  op_a;
	logic signed [9:0]  op_b;
	logic signed [19:0] prod;
	logic [8:0]         sum;
	logic [7:0]         prod_hi;
	logic [7:0]         weighed;

	// One shared multiplier: (s - d) * w for the blends, s * d for multiply,
	// and the inverted channels for screen.
	always_comb begin
		case (ctl.mode)
			MODE_ALPHA, MODE_SRC_ALPHA: begin
				op_a = $signed({2'b00, s}) - $signed({2'b00, d});
				op_b = $signed({2'b00, ctl.weight});
			end
			MODE_SCREEN: begin
				op_a = $signed({2'b00, ~s});
				op_b = $signed({2'b00, ~d});
			end
			default: begin
				op_a = $signed({2'b00, s});
				op_b = $signed({2'b00, d});
			end
		endcase
	end

	assign prod    = op_a * op_b;
	assign prod_hi = prod[15:8];
	// The floor of the signed product over 256 plus d always lands in 0 to 255,
	// so the low byte of the sum is exact.
	assign weighed = d + prod_hi;
	assign sum     = {1'b0, s} + {1'b0, d};

	always_comb begin
		case (ctl.mode)
			MODE_ADD:       y = sum[8] ? CHAN_MAX : sum[7:0];
			MODE_ALPHA:     y = weighed;
			MODE_AVERAGE:   y = {1'b0, s[7:1]} + {1'b0, d[7:1]};
			MODE_DARKEN:    y = (s < d) ? s : d;
			MODE_LIGHTEN:   y = (s > d) ? s : d;
			MODE_DIFF:      y = (s > d) ? (s - d) : (d - s);
			MODE_MULTIPLY:  y = prod_hi;
			MODE_SCREEN:    y = ~prod_hi;
			MODE_SRC_ALPHA: y = weighed;
			MODE_COPY:      y = s;
			default:        y = d;
		endcase
	end

endmodule

/* rtl/pixel_blend_unit.sv */
// Channel   Direction  Handshake             Word
// pix       in         pix_valid, pix_stall  pbu_in_t: mode, source and destination pixel
// res       out        res_valid, res_stall  pbu_out_t: blended pixel
// cfg       in         cfg_valid, cfg_ready  8-bit blend_alpha write data
//
// Every pixel goes from acceptance to result through one input register, one
// pass through the channel datapaths (one multiplier per channel) and one result register.
// One pixel is accepted in every cycle while the result side does not stall.
// Reset clears both stage valid bits and sets blend_alpha to 128.
// A stall on the result side holds the result register; the input register still
// fills, so pix_stall rises only when both stages hold a word.
// cfg_ready is always high; a write takes effect at the next clock edge.
module pixel_blend_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  pbu_pkg::pbu_in_t pix_word,
	output logic             res_valid,
	input  logic             res_stall,
	output pbu_pkg::pbu_out_t res_word,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);
	import pbu_pkg::*;

	logic          pix_valid_s1;
	pbu_in_t       pix_s1;
	logic          res_valid_s2;
	pbu_out_t      res_s2;
	logic [7:0]    blend_alpha_q;
	logic          adv_s1;
	logic          adv_s2;
	pbu_chan_ctl_t chan_ctl;
	pbu_out_t      blended;
	logic [7:0]    alpha_byte;

	// The result register can load when it is empty or its word is leaving.
	// The input register can load when it is empty or its word moves on.
	assign adv_s2    = !res_valid_s2 || !res_stall;
	assign adv_s1    = !pix_valid_s1 || adv_s2;
	assign pix_stall = !adv_s1;
	assign cfg_ready = 1'b1;

	// Configuration register. Writes must come only while the pipeline is empty; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_alpha_q <= BLEND_ALPHA_RST;
		end else if (cfg_valid) begin
			blend_alpha_q <= cfg_data;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				pix_valid_s1 <= pix_valid;
			end
			if (adv_s2) begin
				res_valid_s2 <= pix_valid_s1;
			end
		end
	end

	// Stage payloads load only when a word actually moves in.
	always_ff @(posedge clk) begin
		if (adv_s1 && pix_valid) begin
			pix_s1 <= pix_word;
		end
		if (adv_s2 && pix_valid_s1) begin
			res_s2 <= blended;
		end
	end

	// Source-alpha mode weighs by the source pixel's fourth byte; the
	// constant-alpha mode uses the register.
	assign chan_ctl.mode   = pix_s1.mode;
	assign chan_ctl.weight = (pix_s1.mode == MODE_SRC_ALPHA) ? pix_s1.src_alpha
	                                                         : blend_alpha_q;

	pbu_channel u_blue (
		.ctl (chan_ctl),
		.s   (pix_s1.src_blue),
		.d   (pix_s1.dst_blue),
		.y   (blended.out_blue)
	);

	pbu_channel u_green (
		.ctl (chan_ctl),
		.s   (pix_s1.src_green),
		.d   (pix_s1.dst_green),
		.y   (blended.out_green)
	);

	pbu_channel u_red (
		.ctl (chan_ctl),
		.s   (pix_s1.src_red),
		.d   (pix_s1.dst_red),
		.y   (blended.out_red)
	);

	// The fourth byte is cleared in average mode, taken from the source in copy
	// mode, and passed from the destination in every other mode, undefined ones too.
	always_comb begin
		case (pix_s1.mode)
			MODE_AVERAGE: alpha_byte = 8'd0;
			MODE_COPY:    alpha_byte = pix_s1.src_alpha;
			default:      alpha_byte = pix_s1.dst_alpha;
		endcase
	end

	assign blended.out_alpha = alpha_byte;

	assign res_valid = res_valid_s2;
	assign res_word  = res_s2;

endmodule

/* rtl/pbu_checker.sv */
`include "pixel_blend_unit_defines.svh"

module pbu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_stall,
	input logic              res_valid,
	input logic              res_stall,
	input pbu_pkg::pbu_out_t res_word
);
	import pbu_pkg::*;

	// The input side only backs up when the result side is stalled.
	`PBU_ASSERT_SAME(a_stall_from_res, pix_stall, res_stall)

	// With no result waiting, the block always takes a new word.
	`PBU_ASSERT_SAME(a_empty_accepts, !res_valid, !pix_stall)

	// A new result comes from a word accepted into the input register that then moved into the result register.
	`PBU_ASSERT_SAME(a_rise_has_source, $rose(res_valid), $past(pix_valid && !pix_stall, 2))

	// A stalled result stays and keeps its value.
	`PBU_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word))

endmodule

bind pixel_blend_unit pbu_checker u_pbu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_word  (res_word)
);
